// File: design/led_breathing_heartbeat_controller_macros.svh
// ---------------------------------------------------------------------------
// LED breathing / heartbeat controller assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ---------------------------------------------------------------------------
`ifndef LED_BREATHING_HEARTBEAT_CONTROLLER_MACROS_SVH
`define LED_BREATHING_HEARTBEAT_CONTROLLER_MACROS_SVH

// Plain property that must hold at every clock edge out of reset
`define LBHC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lbhc assertion failed");

// Implication: when the antecedent holds, the consequent holds in the same cycle
`define LBHC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lbhc implication failed");

`endif

// File: design/lbhc_pkg.sv
// ---------------------------------------------------------------------------
// LED breathing / heartbeat controller package
// Shared types, register indexes, breathing state codes and the duty curve.
// ---------------------------------------------------------------------------
`default_nettype none

package lbhc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 24;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_HB_INTERVAL   = 2'd0,
    REG_STEP_INTERVAL = 2'd1,
    REG_LOW_LEVEL     = 2'd2,
    REG_HIGH_LEVEL    = 2'd3
  } cfg_reg_e;

  // Breathing machine states
  typedef enum logic [2:0] {
    BR_IDLE          = 3'd0,
    BR_DARKEN        = 3'd1,
    BR_BRIGHTEN      = 3'd2,
    BR_WAIT_DARKEN   = 3'd3,
    BR_WAIT_BRIGHTEN = 3'd4
  } breath_state_e;

  typedef struct packed {
    logic [15:0] heartbeat_interval;
    logic [7:0]  breath_step_interval;
    logic [7:0]  breath_low_level;
    logic [7:0]  breath_high_level;
  } cfg_t;

  typedef struct packed {
    logic        force_request;
    logic        alt_runtime_active;
    logic        handshake_active;
    logic        shutdown_done;
    logic        inhibited;
    logic        save_done;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [9:0] pwm_duty;
    logic [7:0] led_level;
    logic       update_valid;
  } res_t;

  localparam logic [15:0] HbIntervalRst   = 16'd250;
  localparam logic [7:0]  StepIntervalRst = 8'd4;
  localparam logic [7:0]  LowLevelRst     = 8'h80;
  localparam logic [7:0]  HighLevelRst    = 8'hff;

  localparam logic [9:0] DutyCurve [64] = '{
    10'd0,   10'd1,   10'd1,   10'd2,   10'd2,   10'd2,   10'd2,   10'd2,
    10'd3,   10'd3,   10'd3,   10'd4,   10'd4,   10'd5,   10'd5,   10'd6,
    10'd6,   10'd7,   10'd8,   10'd9,   10'd10,  10'd11,  10'd12,  10'd13,
    10'd15,  10'd17,  10'd19,  10'd21,  10'd23,  10'd26,  10'd29,  10'd32,
    10'd36,  10'd40,  10'd44,  10'd49,  10'd55,  10'd61,  10'd68,  10'd76,
    10'd85,  10'd94,  10'd105, 10'd117, 10'd131, 10'd146, 10'd162, 10'd181,
    10'd202, 10'd225, 10'd250, 10'd279, 10'd311, 10'd346, 10'd386, 10'd430,
    10'd479, 10'd534, 10'd595, 10'd663, 10'd739, 10'd824, 10'd918, 10'd1023
  };

  // Look up the perceptual duty for the upper six bits of a level
  function automatic logic [9:0] duty_lookup(input logic [5:0] idx);
    return DutyCurve[idx];
  endfunction

  // Wrap-safe strict deadline test: now - deadline is positive as a signed word
  function automatic logic time_after(input logic [31:0] now, input logic [31:0] deadline);
    logic [31:0] diff;
    diff = now - deadline;
    return (diff != 32'd0) && !diff[31];
  endfunction

endpackage

`default_nettype wire

// File: design/led_breathing_heartbeat_controller.sv
// ---------------------------------------------------------------------------
// LED breathing / heartbeat controller
// Turns service pass words into LED pattern and PWM duty result words.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one service pass per word: now_ms and six request flags.
//   m_axis returns exactly one result word per pass: update_valid, led_level
//   and pwm_duty (level and duty are zero when update_valid is low).
//   cfg_* writes the four registers; it is always ready and is to be used
//   only while no pass is in flight.
// Pipeline: an accepted pass sits in the input register, is worked out and
//   lands in the output register once that register is free or being
//   emptied: two register stages.
// Throughput: one word per cycle while the output is not stalled, set by the
//   single combinational pass from the input register to the result register.
// Stall: while m_axis_tready is low and a result waits, the input register
//   holds its word; s_axis_tready drops only when both registers are full.
// Reset: registers return to their default values, the heartbeat and the
//   breathing machine return to idle and both channels are empty.
// ---------------------------------------------------------------------------
`default_nettype none

`include "led_breathing_heartbeat_controller_macros.svh"

module led_breathing_heartbeat_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Pass words
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] now_ms, [32] save_done, [33] inhibited, [34] shutdown_done,
  // [35] handshake_active, [36] alt_runtime_active, [37] force_request
  input  wire logic [lbhc_pkg::InDataW-1:0]  s_axis_tdata,
  // Result words
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [0] update_valid, [8:1] led_level, [18:9] pwm_duty
  output logic [lbhc_pkg::OutDataW-1:0]      m_axis_tdata,
  // Register writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lbhc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lbhc_pkg::CfgDataW-1:0] cfg_data_i
);
  import lbhc_pkg::*;

  logic  in_valid_q, in_valid_d;
  item_t in_item_q;
  logic  out_valid_q, out_valid_d;
  res_t  out_res_q;
  logic  advance, in_accept;
  cfg_t  cfg;
  res_t  res;

  lbhc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lbhc_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (in_item_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  // Advance when the result register is free or being emptied
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_accept || (in_valid_q && !advance);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the pass word and the result word
  always_ff @(posedge clk_i) begin
    if (in_accept) in_item_q <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    if (advance)   out_res_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW - $bits(res_t)){1'b0}}, out_res_q};

  `LBHC_ASSERT_IMP(a_out_from_pass, $rose(out_valid_q), $past(in_valid_q))
  `LBHC_ASSERT_IMP(a_stall_cause, !s_axis_tready,
                   in_valid_q && out_valid_q && !m_axis_tready)
  `LBHC_ASSERT_IMP(a_no_update_zero, out_valid_q && !out_res_q.update_valid,
                   out_res_q.led_level == 8'd0 && out_res_q.pwm_duty == 10'd0)

endmodule

`default_nettype wire

// File: design/lbhc_cfg.sv
// ---------------------------------------------------------------------------
// Configuration register file
// Holds the four timing and level registers, written one word at a time.
// ---------------------------------------------------------------------------
`default_nettype none

module lbhc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [lbhc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [lbhc_pkg::CfgDataW-1:0] cfg_data_i,
  output lbhc_pkg::cfg_t                     cfg_o
);
  import lbhc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Always able to take a word
  assign cfg_ready_o = 1'b1;

  // Decode the index and merge the written word
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_HB_INTERVAL:   cfg_d.heartbeat_interval   = cfg_data_i;
        REG_STEP_INTERVAL: cfg_d.breath_step_interval = cfg_data_i[7:0];
        REG_LOW_LEVEL:     cfg_d.breath_low_level     = cfg_data_i[7:0];
        REG_HIGH_LEVEL:    cfg_d.breath_high_level    = cfg_data_i[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.heartbeat_interval   <= HbIntervalRst;
      cfg_q.breath_step_interval <= StepIntervalRst;
      cfg_q.breath_low_level     <= LowLevelRst;
      cfg_q.breath_high_level    <= HighLevelRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/lbhc_step.sv
// ---------------------------------------------------------------------------
// Service pass logic
// Priority selection, heartbeat and breathing machines, and the duty lookup.
// ---------------------------------------------------------------------------
`default_nettype none

`include "led_breathing_heartbeat_controller_macros.svh"

module lbhc_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            advance_i,
  input  wire lbhc_pkg::item_t item_i,
  input  wire lbhc_pkg::cfg_t  cfg_i,
  output lbhc_pkg::res_t       res_o
);
  import lbhc_pkg::*;

  logic          normal_started_q, normal_started_d;
  logic          transition_on_q, transition_on_d;
  breath_state_e breath_state_q, breath_state_d;
  logic [7:0]    breath_level_q, breath_level_d;
  logic [31:0]   breath_deadline_q, breath_deadline_d;
  logic          beat_waiting_q, beat_waiting_d;
  logic [7:0]    beat_level_q, beat_level_d;
  logic [31:0]   beat_deadline_q, beat_deadline_d;

  breath_state_e st;
  logic [7:0]    lvl;
  logic [31:0]   step_deadline;
  logic          beat_due, breath_due, breath_req;
  res_t          res;

  assign step_deadline = item_i.now_ms + 32'(cfg_i.breath_step_interval);
  assign beat_due      = time_after(item_i.now_ms, beat_deadline_q);
  assign breath_due    = time_after(item_i.now_ms, breath_deadline_q);
  assign breath_req    = item_i.handshake_active | item_i.alt_runtime_active |
                         item_i.force_request | transition_on_q;

  // Work out one pass: next state and the result word
  always_comb begin
    normal_started_d  = normal_started_q;
    transition_on_d   = transition_on_q;
    breath_state_d    = breath_state_q;
    breath_level_d    = breath_level_q;
    breath_deadline_d = breath_deadline_q;
    beat_waiting_d    = beat_waiting_q;
    beat_level_d      = beat_level_q;
    beat_deadline_d   = beat_deadline_q;
    res               = '0;
    st                = breath_state_q;
    lvl               = breath_level_q;

    if (item_i.save_done) begin
      res.update_valid = 1'b1;
    end else if (item_i.inhibited) begin
      // Heartbeat: toggle then wait for the deadline to pass
      if (!beat_waiting_q) begin
        res.update_valid = 1'b1;
        res.led_level    = beat_level_q;
        beat_level_d     = ~beat_level_q;
        beat_deadline_d  = item_i.now_ms + 32'(cfg_i.heartbeat_interval);
        beat_waiting_d   = 1'b1;
      end else if (beat_due) begin
        beat_waiting_d = 1'b0;
      end
    end else if (item_i.shutdown_done) begin
      res.update_valid = 1'b1;
    end else if (!normal_started_q) begin
      normal_started_d = 1'b1;
      res.update_valid = 1'b1;
      res.led_level    = cfg_i.breath_high_level;
    end else if (breath_req) begin
      transition_on_d = 1'b1;
      // Idle loads the high level and falls straight into darkening
      if (st == BR_IDLE) begin
        lvl = cfg_i.breath_high_level;
        st  = BR_DARKEN;
      end
      breath_level_d = lvl;
      breath_state_d = st;
      unique case (st)
        BR_DARKEN: begin
          res.update_valid = 1'b1;
          if (lvl != cfg_i.breath_low_level) begin
            breath_level_d    = (lvl > cfg_i.breath_low_level) ? lvl - 8'd1 : lvl + 8'd1;
            breath_deadline_d = step_deadline;
            breath_state_d    = BR_WAIT_DARKEN;
          end else begin
            breath_state_d = BR_BRIGHTEN;
          end
          res.led_level = breath_level_d;
        end
        BR_BRIGHTEN: begin
          res.update_valid = 1'b1;
          if (lvl != cfg_i.breath_high_level) begin
            breath_level_d    = (lvl > cfg_i.breath_high_level) ? lvl - 8'd1 : lvl + 8'd1;
            breath_deadline_d = step_deadline;
            breath_state_d    = BR_WAIT_BRIGHTEN;
          end else if (!item_i.handshake_active && !item_i.alt_runtime_active) begin
            transition_on_d = 1'b0;
            breath_state_d  = BR_IDLE;
          end else begin
            breath_state_d = BR_DARKEN;
          end
          res.led_level = breath_level_d;
        end
        BR_WAIT_DARKEN: begin
          if (breath_due) breath_state_d = BR_DARKEN;
        end
        BR_WAIT_BRIGHTEN: begin
          if (breath_due) breath_state_d = BR_BRIGHTEN;
        end
        default: begin
          breath_state_d = st;
        end
      endcase
    end

    res.pwm_duty = res.update_valid ? duty_lookup(res.led_level[7:2]) : 10'd0;
  end

  // Commit the pass when the word moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_started_q  <= 1'b0;
      transition_on_q   <= 1'b0;
      breath_state_q    <= BR_IDLE;
      breath_level_q    <= 8'd0;
      breath_deadline_q <= 32'd0;
      beat_waiting_q    <= 1'b0;
      beat_level_q      <= 8'd0;
      beat_deadline_q   <= 32'd0;
    end else if (advance_i) begin
      normal_started_q  <= normal_started_d;
      transition_on_q   <= transition_on_d;
      breath_state_q    <= breath_state_d;
      breath_level_q    <= breath_level_d;
      breath_deadline_q <= breath_deadline_d;
      beat_waiting_q    <= beat_waiting_d;
      beat_level_q      <= beat_level_d;
      beat_deadline_q   <= beat_deadline_d;
    end
  end

  assign res_o = res;

  `LBHC_ASSERT(a_beat_level_rails, beat_level_q == 8'h00 || beat_level_q == 8'hff)
  `LBHC_ASSERT_IMP(a_idle_when_off, !transition_on_q, breath_state_q == BR_IDLE)
  `LBHC_ASSERT_IMP(a_started_sticks, $past(normal_started_q), normal_started_q)

endmodule

`default_nettype wire
